// File: src/left_right_load_share_stats_assert.svh
// Assertion macros for the left/right load share statistics block.
// Used by the port checker; needs nothing but a clock and reset in scope.
`ifndef LEFT_RIGHT_LOAD_SHARE_STATS_ASSERT_SVH
`define LEFT_RIGHT_LOAD_SHARE_STATS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LRLS_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrls check failed");

// Next-cycle implication, checked out of reset.
`define LRLS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrls check failed");

`endif

// File: src/lrls_pkg.sv
// Shared types and constants for the left/right load share statistics block.
// Depends on nothing; used by the lane, the top level and the checker.
package lrls_pkg;

  localparam int SENSOR_W = 12;
  localparam int LEG_W    = SENSOR_W + 2;
  localparam int TOT_W    = SENSOR_W + 3;
  localparam int SHARE_W  = 15;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 31;
  localparam int QBITS    = 15;
  localparam int DSH_W    = COUNT_W + QBITS - 1;
  localparam int LIMIT_W  = 9;
  localparam int CFG_W    = 8;

  localparam logic [SHARE_W-1:0] SHARE_FULL = 15'd25600;
  localparam logic [COUNT_W-1:0] COUNT_CAP  = 16'hFFFF;
  localparam logic [7:0]         BAND_HALF  = 8'd5;
  // floor(x / 100) == (x * 5243) >> 19 for every x below 43690.
  localparam logic [12:0]        RECIP_100  = 13'd5243;
  localparam int                 RECIP_SH   = 19;

  typedef enum logic {
    CFG_TARGET = 1'b0,
    CFG_WEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_UPD,
    S_AVGL,
    S_AVGD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] left_sensor_a;
    logic [SENSOR_W-1:0] left_sensor_b;
    logic [SENSOR_W-1:0] left_sensor_c;
    logic [SENSOR_W-1:0] left_sensor_d;
    logic [SENSOR_W-1:0] right_sensor_a;
    logic [SENSOR_W-1:0] right_sensor_b;
    logic [SENSOR_W-1:0] right_sensor_c;
    logic [SENSOR_W-1:0] right_sensor_d;
    logic                last_sample;
  } in_t;

  typedef struct packed {
    logic [SHARE_W-1:0] left_mean;
    logic [SHARE_W-1:0] left_min;
    logic [SHARE_W-1:0] left_max;
    logic [COUNT_W-1:0] left_over_count;
    logic [COUNT_W-1:0] left_under_count;
    logic [SHARE_W-1:0] right_mean;
    logic [SHARE_W-1:0] right_min;
    logic [SHARE_W-1:0] right_max;
    logic [COUNT_W-1:0] right_over_count;
    logic [COUNT_W-1:0] right_under_count;
    logic [COUNT_W-1:0] sample_count;
  } out_t;

  typedef struct packed {
    logic               start_share;
    logic               start_avg;
    logic               step;
    logic               update;
    logic               accum;
    logic               clear;
    logic [COUNT_W-1:0] den;
    logic [LIMIT_W-1:0] upper;
    logic [LIMIT_W-1:0] lower;
    logic               under_en;
  } lane_cmd_t;

  typedef struct packed {
    logic [SHARE_W-1:0] quot;
    logic [SHARE_W-1:0] low;
    logic [SHARE_W-1:0] high;
    logic [COUNT_W-1:0] over;
    logic [COUNT_W-1:0] under;
  } lane_stat_t;

endpackage

// File: src/lrls_lane.sv
// One leg's lane: a bit-serial divider for the share and the average, and
// the leg's running sum, extremes and excursion counters. Uses lrls_pkg.
module lrls_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lrls_pkg::LEG_W-1:0]      leg,
  input  lrls_pkg::lane_cmd_t             cmd,
  output lrls_pkg::lane_stat_t            stat
);

  logic [lrls_pkg::SUM_W-1:0]   rem_r;
  logic [lrls_pkg::DSH_W-1:0]   dsh_r;
  logic [lrls_pkg::SHARE_W-1:0] q_r;
  logic [lrls_pkg::SUM_W-1:0]   sum_r;
  logic [lrls_pkg::SHARE_W-1:0] low_r;
  logic [lrls_pkg::SHARE_W-1:0] high_r;
  logic [lrls_pkg::COUNT_W-1:0] over_r;
  logic [lrls_pkg::COUNT_W-1:0] under_r;
  logic                         fover_r;
  logic                         funder_r;

  logic [lrls_pkg::LEG_W+lrls_pkg::SHARE_W-1:0] num_share;
  logic                                         ge;
  logic                                         over_c;
  logic                                         under_c;

  assign num_share = (lrls_pkg::LEG_W+lrls_pkg::SHARE_W)'(leg) *
                     (lrls_pkg::LEG_W+lrls_pkg::SHARE_W)'(lrls_pkg::SHARE_FULL);
  assign ge        = rem_r >= lrls_pkg::SUM_W'(dsh_r);
  assign over_c    = 17'(q_r) > {cmd.upper, 8'd0};
  assign under_c   = cmd.under_en && (17'(q_r) < {cmd.lower, 8'd0});

  // Restoring division, one quotient bit per step, MSB first.
  always_ff @(posedge clk) begin
    if (cmd.start_share) begin
      rem_r <= lrls_pkg::SUM_W'(num_share);
      dsh_r <= {cmd.den, (lrls_pkg::QBITS-1)'(0)};
      q_r   <= '0;
    end else if (cmd.start_avg) begin
      rem_r <= sum_r;
      dsh_r <= {cmd.den, (lrls_pkg::QBITS-1)'(0)};
      q_r   <= '0;
    end else if (cmd.step) begin
      if (ge) begin
        rem_r <= rem_r - lrls_pkg::SUM_W'(dsh_r);
      end
      q_r   <= {q_r[lrls_pkg::SHARE_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sum_r    <= '0;
      low_r    <= lrls_pkg::SHARE_FULL;
      high_r   <= '0;
      over_r   <= '0;
      under_r  <= '0;
      fover_r  <= 1'b0;
      funder_r <= 1'b0;
    end else if (cmd.update) begin
      if (cmd.accum) begin
        sum_r <= sum_r + lrls_pkg::SUM_W'(q_r);
      end
      if (q_r < low_r) begin
        low_r <= q_r;
      end
      if (q_r > high_r) begin
        high_r <= q_r;
      end
      // A count moves only on entry into an excursion.
      if (over_c) begin
        if (!fover_r && over_r != lrls_pkg::COUNT_CAP) begin
          over_r <= over_r + 16'd1;
        end
        fover_r <= 1'b1;
      end else begin
        fover_r <= 1'b0;
      end
      if (under_c) begin
        if (!funder_r && under_r != lrls_pkg::COUNT_CAP) begin
          under_r <= under_r + 16'd1;
        end
        funder_r <= 1'b1;
      end else begin
        funder_r <= 1'b0;
      end
    end
  end

  assign stat.quot  = q_r;
  assign stat.low   = low_r;
  assign stat.high  = high_r;
  assign stat.over  = over_r;
  assign stat.under = under_r;

endmodule

// File: src/left_right_load_share_stats.sv
// Top level of the left/right load share statistics block: sequencer,
// band limits, sample count and result register. Uses lrls_pkg, lrls_lane.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one beat per sample
//   with four left and four right sensor readings and a last-sample mark.
//   Two lanes, one per leg, divide the leg total by the two-leg total with a
//   bit-serial divider and update that leg's statistics. A sample holds
//   the block through S_MUL, S_DIV and S_UPD (only S_MUL if its total is
//   zero); a last sample adds the average divides through the same lanes,
//   after which the result beat appears on out_valid/out_data.
//   The result stays in its output register until out_ready takes it; the
//   block keeps accepting samples meanwhile and only holds a later result
//   until the register is free.
//   cfg_we/cfg_idx/cfg_data write target_percent (index 0) and
//   weight_percent (index 1); write them only while the block is idle.
//   Synchronous active-low reset restores target 50, weight 100 and clears
//   all statistics. Statistics also clear after each result.
module left_right_load_share_stats #(
  parameter int SENSOR_BITS = 12,
  parameter int MAX_SAMPLES = 65535
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lrls_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lrls_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_idx,
  input  logic [lrls_pkg::CFG_W-1:0]  cfg_data
);

  localparam int USE_BITS = (SENSOR_BITS < lrls_pkg::SENSOR_W) ? SENSOR_BITS
                                                                : lrls_pkg::SENSOR_W;
  localparam int LIMIT_I  = (MAX_SAMPLES < 65535) ? MAX_SAMPLES : 65535;
  localparam logic [lrls_pkg::COUNT_W-1:0] LIMIT = lrls_pkg::COUNT_W'(LIMIT_I);
  localparam logic [lrls_pkg::SENSOR_W-1:0] SMASK =
    lrls_pkg::SENSOR_W'((33'd1 << USE_BITS) - 33'd1);
  localparam logic [3:0] LAST_STEP = 4'(lrls_pkg::QBITS - 1);

  lrls_pkg::state_t state_r, state_nxt;
  logic [3:0]                    cnt_r, cnt_nxt;
  logic [6:0]                    target_r;
  logic [7:0]                    weight_r;
  logic [lrls_pkg::LEG_W-1:0]    lt_r, rt_r;
  logic [lrls_pkg::TOT_W-1:0]    tot_r;
  logic                          last_r;
  logic [lrls_pkg::COUNT_W-1:0]  samples_r;
  logic [15:0]                   hi_prod_r, lo_prod_r;
  logic                          under_en_r;
  logic [lrls_pkg::LIMIT_W-1:0]  upper_r, lower_r;
  lrls_pkg::out_t                out_r;
  logic                          out_valid_r;

  logic [lrls_pkg::LEG_W-1:0]    lt_c, rt_c;
  logic [7:0]                    tp5, tm5;
  logic [28:0]                   up_m, lo_m;
  lrls_pkg::lane_cmd_t           cmd;
  lrls_pkg::lane_stat_t          lstat, rstat;
  logic                          load_out;

  assign lt_c = lrls_pkg::LEG_W'(in_data.left_sensor_a & SMASK)
              + lrls_pkg::LEG_W'(in_data.left_sensor_b & SMASK)
              + lrls_pkg::LEG_W'(in_data.left_sensor_c & SMASK)
              + lrls_pkg::LEG_W'(in_data.left_sensor_d & SMASK);
  assign rt_c = lrls_pkg::LEG_W'(in_data.right_sensor_a & SMASK)
              + lrls_pkg::LEG_W'(in_data.right_sensor_b & SMASK)
              + lrls_pkg::LEG_W'(in_data.right_sensor_c & SMASK)
              + lrls_pkg::LEG_W'(in_data.right_sensor_d & SMASK);

  // Band limits in whole percent; a target below the half band never undercuts.
  assign tp5  = 8'(target_r) + lrls_pkg::BAND_HALF;
  assign tm5  = 8'(target_r) - lrls_pkg::BAND_HALF;
  assign up_m = 29'(hi_prod_r) * 29'(lrls_pkg::RECIP_100);
  assign lo_m = 29'(lo_prod_r) * 29'(lrls_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    hi_prod_r  <= 16'(tp5) * 16'(weight_r);
    lo_prod_r  <= 16'(tm5) * 16'(weight_r);
    under_en_r <= target_r >= 7'(lrls_pkg::BAND_HALF);
    upper_r    <= up_m[lrls_pkg::RECIP_SH +: lrls_pkg::LIMIT_W];
    lower_r    <= lo_m[lrls_pkg::RECIP_SH +: lrls_pkg::LIMIT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 7'd50;
      weight_r <= 8'd100;
    end else if (cfg_we) begin
      if (cfg_idx == lrls_pkg::CFG_TARGET) begin
        target_r <= cfg_data[6:0];
      end else begin
        weight_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    load_out     = 1'b0;
    cmd          = '0;
    cmd.den      = samples_r;
    cmd.upper    = upper_r;
    cmd.lower    = lower_r;
    cmd.under_en = under_en_r;
    cmd.accum    = samples_r < LIMIT;
    case (state_r)
      lrls_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = lrls_pkg::S_MUL;
        end
      end
      lrls_pkg::S_MUL: begin
        cmd.den = lrls_pkg::COUNT_W'(tot_r);
        cnt_nxt = '0;
        if (tot_r != '0) begin
          cmd.start_share = 1'b1;
          state_nxt       = lrls_pkg::S_DIV;
        end else begin
          state_nxt = last_r ? lrls_pkg::S_AVGL : lrls_pkg::S_IDLE;
        end
      end
      lrls_pkg::S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = lrls_pkg::S_UPD;
        end
      end
      lrls_pkg::S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = last_r ? lrls_pkg::S_AVGL : lrls_pkg::S_IDLE;
      end
      lrls_pkg::S_AVGL: begin
        cmd.start_avg = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = lrls_pkg::S_AVGD;
      end
      lrls_pkg::S_AVGD: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = lrls_pkg::S_OUT;
        end
      end
      lrls_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = lrls_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lrls_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrls_pkg::S_IDLE;
      cnt_r       <= '0;
      samples_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cmd.clear) begin
        samples_r <= '0;
      end else if (cmd.update && cmd.accum) begin
        samples_r <= samples_r + 16'd1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lt_r   <= lt_c;
      rt_r   <= rt_c;
      tot_r  <= lrls_pkg::TOT_W'(lt_c) + lrls_pkg::TOT_W'(rt_c);
      last_r <= in_data.last_sample;
    end
    if (load_out) begin
      out_r.left_mean         <= (samples_r == '0) ? '0 : lstat.quot;
      out_r.left_min          <= lstat.low;
      out_r.left_max          <= lstat.high;
      out_r.left_over_count   <= lstat.over;
      out_r.left_under_count  <= lstat.under;
      out_r.right_mean        <= (samples_r == '0) ? '0 : rstat.quot;
      out_r.right_min         <= rstat.low;
      out_r.right_max         <= rstat.high;
      out_r.right_over_count  <= rstat.over;
      out_r.right_under_count <= rstat.under;
      out_r.sample_count      <= samples_r;
    end
  end

  lrls_lane u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .leg   (lt_r),
    .cmd   (cmd),
    .stat  (lstat)
  );

  lrls_lane u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .leg   (rt_r),
    .cmd   (cmd),
    .stat  (rstat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/lrls_checker.sv
// Port-level checker for the load share statistics block, bound to the top.
// Uses lrls_pkg and the assertion macros header.
`include "left_right_load_share_stats_assert.svh"

module lrls_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input lrls_pkg::out_t out_data
);

  logic empty_ok;
  logic mean_ok;

  // With no samples the extremes keep their cleared values.
  assign empty_ok = out_data.left_min == lrls_pkg::SHARE_FULL
                 && out_data.left_max == 15'd0 && out_data.left_mean == 15'd0;
  assign mean_ok  = out_data.left_min <= out_data.left_mean
                 && out_data.left_mean <= out_data.left_max;

  `LRLS_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `LRLS_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `LRLS_IMPLY(a_empty_result, out_valid && out_data.sample_count == 16'd0, empty_ok)
  `LRLS_IMPLY(a_avg_in_range, out_valid && out_data.sample_count != 16'd0, mean_ok)

endmodule

bind left_right_load_share_stats lrls_checker u_lrls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
